/* sv/rsp_pkg.sv */
// Shared types, constants and helper functions for the raycast sprite projector.
// Used by the top level and the divider; depends on nothing else.
`default_nettype none

package rsp_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int TEX_SIZE       = 64;
    localparam int DEPTH_AW       = $clog2(MAX_WIDTH);
    localparam int TEX_AW         = $clog2(TEX_SIZE);
    localparam int TEX_WORDS      = TEX_SIZE * TEX_SIZE;
    localparam int TEX_WORD_AW    = 2 * TEX_AW;
    localparam int NEAR_SLACK     = 45875;
    localparam int SHIFT_DIVIDEND = 6553600;
    localparam int CENTRE_OFFSET  = 128;
    localparam int DIV_DVD_W      = 64;
    localparam int DIV_DVS_W      = 35;
    localparam int DIV_Q_W        = DIV_DVD_W + 1;
    localparam int DIV_CNT_W      = $clog2(DIV_DVD_W);
    localparam logic [31:0] OPAQUE_MASK = 32'h00FF_FFFF;

    typedef enum logic [1:0] {
        MODE_LOAD_DEPTH = 2'd0,
        MODE_LOAD_TEXEL = 2'd1,
        MODE_SET_UP     = 2'd2,
        MODE_SHADE      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_PLAYER_X      = 3'd0,
        REG_PLAYER_Y      = 3'd1,
        REG_DIR_X         = 3'd2,
        REG_DIR_Y         = 3'd3,
        REG_PLANE_X       = 3'd4,
        REG_PLANE_Y       = 3'd5,
        REG_SCREEN_WIDTH  = 3'd6,
        REG_SCREEN_HEIGHT = 3'd7
    } reg_index_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SU_A,
        S_SU_B,
        S_SU_C,
        S_SU_D,
        S_SU_E,
        S_SU_F,
        S_SU_G,
        S_DIV_TX,
        S_DIV_TY,
        S_DIV_SH,
        S_DIV_SC,
        S_DIV_SZ,
        S_SU_BND,
        S_SU_NONE,
        S_SH_A,
        S_SH_B,
        S_SH_TU,
        S_SH_TV,
        S_SH_RD,
        S_SH_TX,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_DVD_W-1:0] dividend;
        logic signed [DIV_DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [DIV_Q_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [DIV_Q_W-1:0] v);
        logic signed [DIV_Q_W-1:0] hi;
        logic signed [DIV_Q_W-1:0] lo;
        hi = DIV_Q_W'(64'sd2147483647);
        lo = DIV_Q_W'(-64'sd2147483648);
        if (v > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < lo)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [DIV_Q_W-1:0] v);
        if (v > DIV_Q_W'(64'sd32767))
        begin
            return 16'sh7FFF;
        end
        else if (v < DIV_Q_W'(-64'sd32768))
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic [14:0] clamp15(input logic signed [DIV_Q_W-1:0] v);
        if (v < 0)
        begin
            return 15'd0;
        end
        else if (v > DIV_Q_W'(64'sd32767))
        begin
            return 15'h7FFF;
        end
        return v[14:0];
    endfunction

endpackage

`default_nettype wire

/* sv/raycast_sprite_projector.sv */
// Top level of the raycast sprite projector: sequencer, datapath and both stores.
// Depends on rsp_pkg, rsp_ram and rsp_div.
`default_nettype none

// One word is taken at a time. A depth or texel load goes straight to the output
// state. Shading a pixel that is rejected by the bounds or depth test passes
// through SH_A and SH_B to the output; a pixel that reaches the texture also
// sends its two texture coordinates, one after the other, through the shared
// divider. Setting up a sprite runs five divisions on that same divider plus
// products on the single shared multiplier. A finished result waits in the
// output register while the next word is accepted. The depth and texture stores
// hold no valid state after reset and must be loaded before they are used.
module raycast_sprite_projector
    import rsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [11:0] load_index,
    input  wire logic [31:0] load_value,
    input  wire logic [15:0] sprite_x,
    input  wire logic [15:0] sprite_y,
    input  wire logic [10:0] column,
    input  wire logic [10:0] row,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             pixel_write,
    output logic [21:0]      pixel_address,
    output logic [31:0]      pixel_color,
    output logic             visible,
    output logic [10:0]      first_column,
    output logic [10:0]      last_column,
    output logic [10:0]      first_row,
    output logic [10:0]      last_row
);

    function automatic logic [10:0] clamp11(input logic signed [17:0] v);
        if (v < 0)
        begin
            return 11'd0;
        end
        else if (v > 18'sd2047)
        begin
            return 11'h7FF;
        end
        return v[10:0];
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [15:0]        player_x_reg;
    logic [15:0]        player_y_reg;
    logic signed [15:0] dir_x_reg;
    logic signed [15:0] dir_y_reg;
    logic signed [15:0] plane_x_reg;
    logic signed [15:0] plane_y_reg;
    logic [11:0]        width_reg;
    logic [11:0]        height_reg;

    logic signed [31:0] spr_depth_reg;
    logic signed [15:0] spr_col_reg;
    logic [14:0]        spr_size_reg;
    logic [14:0]        spr_shift_reg;
    logic [10:0]        bnd_reg [4];
    logic               spr_valid_reg;

    logic signed [17:0] rx_reg;
    logic signed [17:0] ry_reg;
    logic signed [32:0] det_reg;
    logic signed [34:0] num_reg;
    logic signed [31:0] tx_reg;
    logic signed [52:0] prod_reg;
    logic [10:0]        col_reg;
    logic [10:0]        row_reg;
    logic               hit_reg;
    logic signed [17:0] dxp_reg;
    logic signed [25:0] dyp_reg;
    logic [TEX_AW-1:0]  tu_reg;
    logic [TEX_AW-1:0]  tv_reg;

    logic               res_write_reg;
    logic [21:0]        res_addr_reg;
    logic [31:0]        res_color_reg;
    logic               res_sprite_reg;

    logic               out_valid_reg;
    logic               pixel_write_reg;
    logic [21:0]        pixel_address_reg;
    logic [31:0]        pixel_color_reg;
    logic               visible_reg;
    logic [10:0]        first_column_reg;
    logic [10:0]        last_column_reg;
    logic [10:0]        first_row_reg;
    logic [10:0]        last_row_reg;

    logic               accept;
    logic               out_free;
    logic signed [33:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [52:0] mul_p;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic signed [31:0] ty_q;
    logic [14:0]        size_q;
    logic [14:0]        tex_q;

    logic                   depth_we;
    logic [DEPTH_AW-1:0]    depth_rd_addr;
    logic [31:0]            depth_rd;
    logic                   tex_we;
    logic [TEX_WORD_AW-1:0] tex_rd_addr;
    logic [31:0]            tex_rd;

    logic signed [17:0] half_s;
    logic signed [17:0] col_s;
    logic signed [17:0] w_s;
    logic signed [17:0] h_s;
    logic signed [17:0] y0;
    logic signed [17:0] y1;
    logic signed [17:0] x0;
    logic signed [17:0] x1;
    logic signed [25:0] row_rel;
    logic signed [17:0] dxp;
    logic signed [25:0] dyp;
    logic               hit;
    logic [32:0]        slack_sum;
    logic               too_far;
    logic               shade_go;
    logic [DIV_DVD_W-1:0] tu_dvd;
    logic [DIV_DVD_W-1:0] tv_dvd;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign mul_p    = mul_a * mul_b;
    assign ty_q     = sat32(div_rsp.quotient);
    assign size_q   = clamp15(div_rsp.quotient >>> 1);

    always_comb
    begin
        if (div_rsp.quotient >>> 8 > DIV_Q_W'(TEX_SIZE - 1))
        begin
            tex_q = 15'(TEX_SIZE - 1);
        end
        else
        begin
            tex_q = div_rsp.quotient[22:8];
        end
    end

    always_comb
    begin
        half_s  = $signed({4'b0, spr_size_reg[14:1]});
        col_s   = 18'(spr_col_reg);
        w_s     = $signed({6'b0, width_reg});
        h_s     = $signed({6'b0, height_reg});
        y0      = $signed({3'b0, spr_shift_reg}) + $signed({7'b0, height_reg[11:1]}) - half_s;
        y1      = $signed({3'b0, spr_shift_reg}) + $signed({7'b0, height_reg[11:1]}) + half_s;
        x0      = col_s - half_s;
        x1      = col_s + half_s;
        if (y1 >= h_s)
        begin
            y1 = h_s - 18'sd1;
        end
        if (x1 >= w_s)
        begin
            x1 = w_s - 18'sd1;
        end
        row_rel = $signed({15'b0, row_reg}) - $signed({11'b0, spr_shift_reg});
        dxp     = $signed({7'b0, col_reg}) - col_s + half_s;
        dyp     = (row_rel <<< 8) - $signed({7'b0, height_reg, 7'b0})
                  + $signed({4'b0, spr_size_reg, 7'b0});
        hit     = spr_valid_reg
                  && col_reg >= bnd_reg[0] && col_reg < bnd_reg[1]
                  && row_reg >= bnd_reg[2] && row_reg < bnd_reg[3]
                  && col_reg != 11'd0 && {1'b0, col_reg} < width_reg
                  && 32'(col_reg) < MAX_WIDTH;
        slack_sum = {1'b0, depth_rd} + 33'(NEAR_SLACK);
        too_far   = {1'b0, spr_depth_reg} > slack_sum;
        shade_go  = hit_reg && !too_far;
        tu_dvd    = dxp_reg[17] ? '0 : (DIV_DVD_W'(unsigned'(dxp_reg)) << (8 + TEX_AW));
        tv_dvd    = dyp_reg[25] ? '0 : (DIV_DVD_W'(unsigned'(dyp_reg)) << TEX_AW);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (mode_t'(mode))
                        MODE_LOAD_DEPTH: state_next = S_OUT;
                        MODE_LOAD_TEXEL: state_next = S_OUT;
                        MODE_SET_UP:     state_next = S_SU_A;
                        MODE_SHADE:      state_next = S_SH_A;
                        default:         state_next = S_OUT;
                    endcase
                end
            end
            S_SU_A: state_next = S_SU_B;
            S_SU_B: state_next = S_SU_C;
            S_SU_C: state_next = S_SU_D;
            S_SU_D: state_next = (det_reg == '0) ? S_SU_NONE : S_SU_E;
            S_SU_E: state_next = S_SU_F;
            S_SU_F: state_next = S_SU_G;
            S_SU_G: state_next = S_DIV_TX;
            S_DIV_TX:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DIV_TY;
                end
            end
            S_DIV_TY:
            begin
                if (div_rsp.done)
                begin
                    state_next = (ty_q <= 0) ? S_SU_NONE : S_DIV_SH;
                end
            end
            S_DIV_SH:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DIV_SC;
                end
            end
            S_DIV_SC:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DIV_SZ;
                end
            end
            S_DIV_SZ:
            begin
                if (div_rsp.done)
                begin
                    state_next = (size_q == '0) ? S_SU_NONE : S_SU_BND;
                end
            end
            S_SU_BND:  state_next = S_OUT;
            S_SU_NONE: state_next = S_OUT;
            S_SH_A:    state_next = S_SH_B;
            S_SH_B:    state_next = shade_go ? S_SH_TU : S_OUT;
            S_SH_TU:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_SH_TV;
                end
            end
            S_SH_TV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD: state_next = S_SH_TX;
            S_SH_TX: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready         = state_reg == S_IDLE;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        depth_we         = accept && mode_t'(mode) == MODE_LOAD_DEPTH
                           && 32'(load_index) < MAX_WIDTH;
        tex_we           = accept && mode_t'(mode) == MODE_LOAD_TEXEL
                           && 32'(load_index) < TEX_WORDS;
        depth_rd_addr    = DEPTH_AW'(col_reg);
        tex_rd_addr      = {tv_reg, tu_reg};
        unique case (state_reg)
            S_SU_A:
            begin
                mul_a = 34'(plane_x_reg);
                mul_b = 19'(dir_y_reg);
            end
            S_SU_B:
            begin
                mul_a = 34'(dir_x_reg);
                mul_b = 19'(plane_y_reg);
            end
            S_SU_C:
            begin
                mul_a = 34'(dir_y_reg);
                mul_b = 19'(rx_reg);
            end
            S_SU_D:
            begin
                mul_a = 34'(dir_x_reg);
                mul_b = 19'(ry_reg);
            end
            S_SU_E:
            begin
                mul_a = 34'(plane_x_reg);
                mul_b = 19'(ry_reg);
            end
            S_SU_F:
            begin
                mul_a            = 34'(plane_y_reg);
                mul_b            = 19'(rx_reg);
                div_req.start    = 1'b1;
                div_req.dividend = {{7{num_reg[34]}}, num_reg, 22'd0};
                div_req.divisor  = 35'(det_reg);
            end
            S_DIV_TX:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {{7{num_reg[34]}}, num_reg, 22'd0};
                div_req.divisor  = 35'(det_reg);
            end
            S_DIV_TY:
            begin
                div_req.start    = div_rsp.done && ty_q > 0;
                div_req.dividend = 64'(SHIFT_DIVIDEND);
                div_req.divisor  = 35'(ty_q);
            end
            S_DIV_SH:
            begin
                mul_a            = 34'(spr_depth_reg) + 34'(tx_reg);
                mul_b            = $signed({8'b0, width_reg[11:1]});
                div_req.start    = div_rsp.done;
                div_req.dividend = 64'(prod_reg);
                div_req.divisor  = 35'(spr_depth_reg);
            end
            S_DIV_SC:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = $signed({36'd0, height_reg, 16'd0});
                div_req.divisor  = 35'(spr_depth_reg);
            end
            S_SH_A:
            begin
                mul_a = $signed({23'b0, row_reg});
                mul_b = $signed({7'b0, width_reg});
            end
            S_SH_B:
            begin
                div_req.start    = shade_go;
                div_req.dividend = $signed(tu_dvd);
                div_req.divisor  = $signed({20'b0, spr_size_reg});
            end
            S_SH_TU:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = $signed(tv_dvd);
                div_req.divisor  = $signed({20'b0, spr_size_reg});
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg <= 16'd0;
            player_y_reg <= 16'd0;
            dir_x_reg    <= 16'sd16384;
            dir_y_reg    <= 16'sd0;
            plane_x_reg  <= 16'sd0;
            plane_y_reg  <= 16'sd10813;
            width_reg    <= 12'd640;
            height_reg   <= 12'd480;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_PLAYER_X:      player_x_reg <= cfg_data;
                REG_PLAYER_Y:      player_y_reg <= cfg_data;
                REG_DIR_X:         dir_x_reg    <= cfg_data;
                REG_DIR_Y:         dir_y_reg    <= cfg_data;
                REG_PLANE_X:       plane_x_reg  <= cfg_data;
                REG_PLANE_Y:       plane_y_reg  <= cfg_data;
                REG_SCREEN_WIDTH:  width_reg    <= cfg_data[11:0];
                REG_SCREEN_HEIGHT: height_reg   <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_depth_reg <= '0;
            spr_col_reg   <= '0;
            spr_size_reg  <= '0;
            spr_shift_reg <= '0;
            spr_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                bnd_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_DIV_TY:
                begin
                    if (div_rsp.done)
                    begin
                        spr_depth_reg <= ty_q;
                    end
                end
                S_DIV_SH:
                begin
                    if (div_rsp.done)
                    begin
                        spr_shift_reg <= clamp15(div_rsp.quotient);
                    end
                end
                S_DIV_SC:
                begin
                    if (div_rsp.done)
                    begin
                        spr_col_reg <= sat16(div_rsp.quotient);
                    end
                end
                S_DIV_SZ:
                begin
                    if (div_rsp.done)
                    begin
                        spr_size_reg <= size_q;
                    end
                end
                S_SU_BND:
                begin
                    bnd_reg[0]    <= clamp11(x0);
                    bnd_reg[1]    <= clamp11(x1);
                    bnd_reg[2]    <= clamp11(y0);
                    bnd_reg[3]    <= clamp11(y1);
                    spr_valid_reg <= 1'b1;
                end
                S_SU_NONE:
                begin
                    spr_depth_reg <= '0;
                    spr_col_reg   <= '0;
                    spr_size_reg  <= '0;
                    spr_shift_reg <= '0;
                    spr_valid_reg <= 1'b0;
                    for (int i = 0; i < 4; i++)
                    begin
                        bnd_reg[i] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (accept)
        begin
            rx_reg         <= $signed({2'b0, sprite_x}) + 18'sd128 - $signed({2'b0, player_x_reg});
            ry_reg         <= $signed({2'b0, sprite_y}) + 18'(CENTRE_OFFSET)
                              - $signed({2'b0, player_y_reg});
            col_reg        <= column;
            row_reg        <= row;
            res_write_reg  <= 1'b0;
            res_addr_reg   <= '0;
            res_color_reg  <= '0;
            res_sprite_reg <= mode_t'(mode) == MODE_SET_UP || mode_t'(mode) == MODE_SHADE;
        end
        unique case (state_reg)
            S_SU_B: det_reg <= prod_reg[32:0];
            S_SU_C: det_reg <= det_reg - prod_reg[32:0];
            S_SU_D: num_reg <= prod_reg[34:0];
            S_SU_E: num_reg <= num_reg - prod_reg[34:0];
            S_SU_F: num_reg <= prod_reg[34:0];
            S_SU_G: num_reg <= num_reg - prod_reg[34:0];
            S_DIV_TX:
            begin
                if (div_rsp.done)
                begin
                    tx_reg <= ty_q;
                end
            end
            S_SH_A:
            begin
                hit_reg <= hit;
                dxp_reg <= dxp;
                dyp_reg <= dyp;
            end
            S_SH_B: res_addr_reg <= prod_reg[21:0] + 22'(col_reg);
            S_SH_TU:
            begin
                if (div_rsp.done)
                begin
                    tu_reg <= tex_q[TEX_AW-1:0];
                end
            end
            S_SH_TV:
            begin
                if (div_rsp.done)
                begin
                    tv_reg <= tex_q[TEX_AW-1:0];
                end
            end
            S_SH_TX:
            begin
                if ((tex_rd & OPAQUE_MASK) != '0)
                begin
                    res_write_reg <= 1'b1;
                    res_color_reg <= tex_rd;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            pixel_write_reg   <= res_write_reg;
            pixel_address_reg <= res_addr_reg;
            pixel_color_reg   <= res_color_reg;
            visible_reg       <= res_sprite_reg && spr_valid_reg;
            first_column_reg  <= res_sprite_reg ? bnd_reg[0] : 11'd0;
            last_column_reg   <= res_sprite_reg ? bnd_reg[1] : 11'd0;
            first_row_reg     <= res_sprite_reg ? bnd_reg[2] : 11'd0;
            last_row_reg      <= res_sprite_reg ? bnd_reg[3] : 11'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_write   = pixel_write_reg;
    assign pixel_address = pixel_address_reg;
    assign pixel_color   = pixel_color_reg;
    assign visible       = visible_reg;
    assign first_column  = first_column_reg;
    assign last_column   = last_column_reg;
    assign first_row     = first_row_reg;
    assign last_row      = last_row_reg;

    rsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rsp_ram #(
        .ADDR_W (DEPTH_AW),
        .DATA_W (32)
    ) u_depth_store (
        .clk     (clk),
        .wr_en   (depth_we),
        .wr_addr (DEPTH_AW'(load_index)),
        .wr_data (load_value),
        .rd_addr (depth_rd_addr),
        .rd_data (depth_rd)
    );

    rsp_ram #(
        .ADDR_W (TEX_WORD_AW),
        .DATA_W (32)
    ) u_texture_store (
        .clk     (clk),
        .wr_en   (tex_we),
        .wr_addr (TEX_WORD_AW'(load_index)),
        .wr_data (load_value),
        .rd_addr (tex_rd_addr),
        .rd_data (tex_rd)
    );

    // A drawn pixel always belongs to a visible sprite with non-empty bounds.
    a_write_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pixel_write) |-> (visible && first_column < last_column
                                        && first_row < last_row))
        else $error("pixel written outside a visible sprite");

    a_invisible_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> (!pixel_write && first_column == 11'd0
            && last_column == 11'd0 && first_row == 11'd0 && last_row == 11'd0))
        else $error("invisible result carries bounds or a write");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("sequencer stayed idle after taking a word");

    a_div_done_awaited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_TX || state_reg == S_DIV_TY
            || state_reg == S_DIV_SH || state_reg == S_DIV_SC
            || state_reg == S_DIV_SZ || state_reg == S_SH_TU
            || state_reg == S_SH_TV))
        else $error("divider finished while nothing waited for it");

endmodule

`default_nettype wire

/* sv/rsp_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered, available in the cycle after the address; no dependencies.
`default_nettype none

module rsp_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* sv/rsp_div.sv */
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on rsp_pkg for the request and response structs.
`default_nettype none

module rsp_div
    import rsp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DVS_W-1:0] rem_reg;
    logic [DIV_DVD_W-1:0] quo_reg;
    logic [DIV_DVS_W-1:0] den_reg;
    logic                 neg_reg;

    logic [DIV_DVD_W-1:0] dvd_mag;
    logic [DIV_DVS_W-1:0] dvs_mag;
    logic [DIV_DVS_W:0]   trial;
    logic [DIV_DVS_W:0]   diff;
    logic                 fits;
    logic [DIV_Q_W-1:0]   quo_ext;

    always_comb
    begin
        dvd_mag = req.dividend[DIV_DVD_W-1] ? DIV_DVD_W'(-req.dividend)
                                             : DIV_DVD_W'(req.dividend);
        dvs_mag = req.divisor[DIV_DVS_W-1] ? DIV_DVS_W'(-req.divisor)
                                            : DIV_DVS_W'(req.divisor);
        trial   = {rem_reg, quo_reg[DIV_DVD_W-1]};
        diff    = trial - {1'b0, den_reg};
        fits    = trial >= {1'b0, den_reg};
        quo_ext = {1'b0, quo_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= dvd_mag;
            den_reg <= dvs_mag;
            neg_reg <= req.dividend[DIV_DVD_W-1] ^ req.divisor[DIV_DVS_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_DVD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_ext) : $signed(quo_ext);

endmodule

`default_nettype wire
